// ===== rtl/sph_pkg.sv =====
package sph_pkg;

   localparam int WORD_W  = 30;
   localparam int QUERY_W = 4;

   localparam logic [WORD_W-1:0] HASH_PRIME = WORD_W'(1000000007);
   localparam logic [WORD_W-1:0] HASH_EXP   = WORD_W'(1000000005);
   localparam logic [WORD_W-1:0] BASE_RESET = WORD_W'(33);
   localparam logic [WORD_W-1:0] ONE_VALUE  = WORD_W'(1);
   localparam logic [7:0]        CHAR_OFFSET = 8'd96;

   // modular multiplier: bits of the multiplier retired per cycle
   localparam int MUL_STEPS = 2;

   localparam int POW_W = $clog2(WORD_W);
   localparam logic [POW_W-1:0] POW_LAST = POW_W'(WORD_W - 1);

   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_QUERY = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic               func;
      logic               restart;
      logic [7:0]         char_code;
      logic [QUERY_W-1:0] query_start;
      logic [QUERY_W-1:0] query_end;
   } sph_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] hash_value;
      logic [1:0]        status;
   } sph_rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } sph_mul_op_type;

endpackage

// ===== rtl/substring_polynomial_hash_unit.sv =====
// Polynomial substring hash modulo 1e9+7. An append beat adds one character
// (value = code - 96 mod p) and returns the new prefix hash; a query beat
// (start, end) returns (prefix[end] - prefix[start-1]) * base^-start mod p,
// the substring hash normalized to position zero. One result beat per item.
// Prefix hashes and inverse powers live in one synchronous RAM of
// MAX_LENGTH entries with a registered read; one modular multiplier, which
// retires two multiplier bits per cycle, does all the arithmetic. A query
// does three RAM reads and one multiplication. An append does one RAM read
// and three multiplications in turn. An append at position zero skips the
// read and the inverse multiplication, but first raises the base to p-2 by
// square-and-multiply, 44 more multiplications. Items are worked one at a
// time; the result register lets the next item in while a result beat waits.
// The base register may be written only while the block is idle.
module substring_polynomial_hash_unit import sph_pkg::*; #(
   parameter int MAX_LENGTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sph_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sph_rsp_type       rsp_data,
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data
);

   localparam int CNT_W   = $clog2(MAX_LENGTH + 1);
   localparam int ADDR_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int ENTRY_W = 2 * WORD_W;
   localparam int CMP_W   = (CNT_W > QUERY_W) ? CNT_W : QUERY_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LENGTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POW_STEP,
      ST_POW_R_WAIT,
      ST_POW_SQ,
      ST_POW_B_WAIT,
      ST_A_READ,
      ST_A_INV_WAIT,
      ST_A_TERM_WAIT,
      ST_A_RUN_WAIT,
      ST_Q_HI,
      ST_Q_INV,
      ST_Q_LO,
      ST_Q_MUL_WAIT,
      ST_RESULT
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [WORD_W-1:0] base_cfg_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] run_ff, run_in;
   logic [WORD_W-1:0] binv_ff, binv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              mul_start_ff, mul_start_in;

   // datapath
   sph_req_type       item_ff, item_in;
   logic [WORD_W-1:0] base_ff, base_in;
   logic [WORD_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [WORD_W-1:0] prev_prefix_ff, prev_prefix_in;
   logic [WORD_W-1:0] new_inv_ff, new_inv_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic [1:0]        status_ff, status_in;
   logic [WORD_W-1:0] pow_r_ff, pow_r_in;
   logic [WORD_W-1:0] pow_b_ff, pow_b_in;
   logic [POW_W-1:0]  pow_bit_ff, pow_bit_in;
   sph_mul_op_type    mul_op_ff, mul_op_in;
   sph_rsp_type       rsp_data_ff, rsp_data_in;

   // RAM: {prefix_hash, inverse_power} per position
   logic [ENTRY_W-1:0] store_mem [MAX_LENGTH];
   logic [ENTRY_W-1:0] mem_rdata_ff;
   logic [ADDR_W-1:0]  mem_raddr;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [WORD_W-1:0]  rd_prefix;
   logic [WORD_W-1:0]  rd_inv;

   logic              mul_done;
   logic [WORD_W-1:0] mul_product;

   logic [WORD_W-1:0] base_reduced;
   logic [CNT_W-1:0]  count_eff;
   logic              query_bad;
   logic [WORD_W-1:0] char_value;
   logic [WORD_W-1:0] prefix_sum;
   logic [WORD_W-1:0] lo_prefix;
   logic [WORD_W-1:0] hash_diff;
   logic              rsp_free;

   sph_modmul u_modmul (
      .clock       (clock),
      .reset       (reset),
      .mul_start   (mul_start_ff),
      .mul_op      (mul_op_ff),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   assign rd_prefix = mem_rdata_ff[ENTRY_W-1:WORD_W];
   assign rd_inv    = mem_rdata_ff[WORD_W-1:0];

   // base register holds at most 2^30-1, below 2p: one subtract reduces it
   assign base_reduced = (base_cfg_ff >= HASH_PRIME) ? base_cfg_ff - HASH_PRIME : base_cfg_ff;

   // restart drops the loaded string before the append is placed
   assign count_eff = item_ff.restart ? '0 : count_ff;

   assign query_bad = (item_ff.query_start > item_ff.query_end) ||
                      (CMP_W'(item_ff.query_end) >= CMP_W'(count_ff));

   // codes below 'a'-1 wrap around the prime
   assign char_value = (item_ff.char_code >= CHAR_OFFSET) ?
                       WORD_W'(item_ff.char_code - CHAR_OFFSET) :
                       HASH_PRIME - WORD_W'(CHAR_OFFSET - item_ff.char_code);

   // prefix[i] = prefix[i-1] + run * value, reduced once
   always_comb begin
      logic [WORD_W:0] sum;
      sum = {1'b0, prev_prefix_ff} + {1'b0, mul_product};
      if (sum >= {1'b0, HASH_PRIME}) begin
         sum = sum - {1'b0, HASH_PRIME};
      end
      prefix_sum = sum[WORD_W-1:0];
   end

   // prefix[end] - prefix[start-1], wrapped into range
   assign lo_prefix = (item_ff.query_start == '0) ? '0 : rd_prefix;

   always_comb begin
      logic [WORD_W:0] diff;
      if (prev_prefix_ff >= lo_prefix) begin
         diff = {1'b0, prev_prefix_ff} - {1'b0, lo_prefix};
      end else begin
         diff = {1'b0, prev_prefix_ff} + {1'b0, HASH_PRIME} - {1'b0, lo_prefix};
      end
      hash_diff = diff[WORD_W-1:0];
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Read address per state; data shows up one state later.
   always_comb begin
      case (state_ff)
         ST_DECODE: begin
            if (item_ff.func == FUNC_QUERY) begin
               mem_raddr = ADDR_W'(item_ff.query_end);
            end else begin
               mem_raddr = ADDR_W'(count_eff - CNT_W'(1));
            end
         end
         ST_Q_HI:  mem_raddr = ADDR_W'(item_ff.query_start);
         ST_Q_INV: begin
            if (item_ff.query_start == '0) begin
               mem_raddr = '0;
            end else begin
               mem_raddr = ADDR_W'(item_ff.query_start - QUERY_W'(1));
            end
         end
         default:  mem_raddr = idx_ff;
      endcase
   end

   assign mem_we    = (state_ff == ST_A_TERM_WAIT) && mul_done;
   assign mem_waddr = idx_ff;
   assign mem_wdata = {prefix_sum, new_inv_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= store_mem[mem_raddr];
   end

   // Sequencer: one item at a time, every multiply goes through the shared unit.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      run_in         = run_ff;
      binv_in        = binv_ff;
      mul_start_in   = 1'b0;
      mul_op_in      = mul_op_ff;
      item_in        = item_ff;
      base_in        = base_ff;
      val_in         = val_ff;
      idx_in         = idx_ff;
      prev_prefix_in = prev_prefix_ff;
      new_inv_in     = new_inv_ff;
      hash_in        = hash_ff;
      status_in      = status_ff;
      pow_r_in       = pow_r_ff;
      pow_b_in       = pow_b_ff;
      pow_bit_in     = pow_bit_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            // latch the beat and the base it is worked with
            if (req_valid) begin
               item_in  = req_data;
               base_in  = base_reduced;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            if (item_ff.func == FUNC_APPEND) begin
               if (count_eff == CNT_FULL) begin
                  hash_in   = '0;
                  status_in = STATUS_FULL;
                  state_in  = ST_RESULT;
               end else begin
                  idx_in = ADDR_W'(count_eff);
                  val_in = char_value;
                  if (count_eff == '0) begin
                     // new string: find base^(p-2) first
                     pow_r_in   = ONE_VALUE;
                     pow_b_in   = base_ff;
                     pow_bit_in = '0;
                     state_in   = ST_POW_STEP;
                  end else begin
                     state_in = ST_A_READ;
                  end
               end
            end else if (query_bad) begin
               hash_in   = '0;
               status_in = STATUS_BAD_QUERY;
               state_in  = ST_RESULT;
            end else begin
               state_in = ST_Q_HI;
            end
         end

         ST_POW_STEP: begin
            if (HASH_EXP[pow_bit_ff]) begin
               mul_start_in = 1'b1;
               mul_op_in    = '{a: pow_r_ff, b: pow_b_ff};
               state_in     = ST_POW_R_WAIT;
            end else begin
               state_in = ST_POW_SQ;
            end
         end

         ST_POW_R_WAIT: begin
            if (mul_done) begin
               pow_r_in = mul_product;
               state_in = ST_POW_SQ;
            end
         end

         ST_POW_SQ: begin
            if (pow_bit_ff == POW_LAST) begin
               // inverse ready: position zero has run = 1 and inverse power 1
               binv_in        = pow_r_ff;
               run_in         = ONE_VALUE;
               new_inv_in     = ONE_VALUE;
               prev_prefix_in = '0;
               mul_start_in   = 1'b1;
               mul_op_in      = '{a: ONE_VALUE, b: val_ff};
               state_in       = ST_A_TERM_WAIT;
            end else begin
               mul_start_in = 1'b1;
               mul_op_in    = '{a: pow_b_ff, b: pow_b_ff};
               state_in     = ST_POW_B_WAIT;
            end
         end

         ST_POW_B_WAIT: begin
            if (mul_done) begin
               pow_b_in   = mul_product;
               pow_bit_in = pow_bit_ff + POW_W'(1);
               state_in   = ST_POW_STEP;
            end
         end

         ST_A_READ: begin
            // entry i-1 is on the read port
            prev_prefix_in = rd_prefix;
            mul_start_in   = 1'b1;
            mul_op_in      = '{a: rd_inv, b: binv_ff};
            state_in       = ST_A_INV_WAIT;
         end

         ST_A_INV_WAIT: begin
            if (mul_done) begin
               new_inv_in   = mul_product;
               mul_start_in = 1'b1;
               mul_op_in    = '{a: run_ff, b: val_ff};
               state_in     = ST_A_TERM_WAIT;
            end
         end

         ST_A_TERM_WAIT: begin
            // entry i is written here; advance the running power next
            if (mul_done) begin
               hash_in      = prefix_sum;
               mul_start_in = 1'b1;
               mul_op_in    = '{a: run_ff, b: base_ff};
               state_in     = ST_A_RUN_WAIT;
            end
         end

         ST_A_RUN_WAIT: begin
            if (mul_done) begin
               run_in    = mul_product;
               count_in  = CNT_W'(idx_ff) + CNT_W'(1);
               status_in = STATUS_OK;
               state_in  = ST_RESULT;
            end
         end

         ST_Q_HI: begin
            prev_prefix_in = rd_prefix;
            state_in       = ST_Q_INV;
         end

         ST_Q_INV: begin
            new_inv_in = rd_inv;
            state_in   = ST_Q_LO;
         end

         ST_Q_LO: begin
            mul_start_in = 1'b1;
            mul_op_in    = '{a: hash_diff, b: new_inv_ff};
            state_in     = ST_Q_MUL_WAIT;
         end

         ST_Q_MUL_WAIT: begin
            if (mul_done) begin
               hash_in   = mul_product;
               status_in = STATUS_OK;
               state_in  = ST_RESULT;
            end
         end

         ST_RESULT: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{hash_value: hash_ff, status: status_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_cfg_ff  <= BASE_RESET;
         count_ff     <= '0;
         run_ff       <= ONE_VALUE;
         binv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
         binv_ff      <= binv_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_start_ff <= mul_start_in;
         if (csr_wr_en) begin
            base_cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      base_ff        <= base_in;
      val_ff         <= val_in;
      idx_ff         <= idx_in;
      prev_prefix_ff <= prev_prefix_in;
      new_inv_ff     <= new_inv_in;
      hash_ff        <= hash_in;
      status_ff      <= status_in;
      pow_r_ff       <= pow_r_in;
      pow_b_ff       <= pow_b_in;
      pow_bit_ff     <= pow_bit_in;
      mul_op_ff      <= mul_op_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ok_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_OK) |->
         (rsp_data_ff.hash_value < HASH_PRIME))
      else $error("hash result not reduced");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("loaded count beyond depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < 32'(MAX_LENGTH) && CNT_W'(mem_waddr) < CNT_FULL))
      else $error("RAM write outside the string");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT)
      else $error("result beat without a finished item");

endmodule

// ===== rtl/sph_modmul.sv =====
module sph_modmul import sph_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              mul_start,
   input  sph_mul_op_type    mul_op,
   output logic              mul_done,
   output logic [WORD_W-1:0] mul_product
);

   localparam int CYCLES = WORD_W / MUL_STEPS;
   localparam int CNT_W  = $clog2(CYCLES);
   localparam int SUM_W  = WORD_W + 2;
   localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(CYCLES - 1);
   localparam logic [SUM_W-1:0] PRIME_EXT  = SUM_W'(HASH_PRIME);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] acc_in;
   logic [WORD_W-1:0] mcand_ff;
   logic [WORD_W-1:0] mplier_ff;
   logic [WORD_W-1:0] mplier_in;

   // MSB-first shift-add: acc = 2*acc + bit*a, then fold back below the prime
   always_comb begin
      logic [SUM_W-1:0]  acc;
      logic [WORD_W-1:0] mp;
      acc = SUM_W'(acc_ff);
      mp  = mplier_ff;
      for (int s = 0; s < MUL_STEPS; s++) begin
         acc = (acc << 1) + (mp[WORD_W-1] ? SUM_W'(mcand_ff) : '0);
         if (acc >= PRIME_EXT) begin
            acc = acc - PRIME_EXT;
         end
         if (acc >= PRIME_EXT) begin
            acc = acc - PRIME_EXT;
         end
         mp = mp << 1;
      end
      acc_in    = acc[WORD_W-1:0];
      mplier_in = mp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !mul_start && busy_ff && (cnt_ff == CNT_LAST);
         if (mul_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         acc_ff    <= '0;
         mcand_ff  <= mul_op.a;
         mplier_ff <= mul_op.b;
         cnt_ff    <= '0;
      end else if (busy_ff) begin
         acc_ff    <= acc_in;
         mplier_ff <= mplier_in;
         cnt_ff    <= cnt_ff + CNT_W'(1);
      end
   end

   assign mul_done    = done_ff;
   assign mul_product = acc_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !busy_ff)
      else $error("multiply started while busy");

   a_done_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (acc_ff < HASH_PRIME))
      else $error("product not reduced");

   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("busy dropped without done");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench import sph_pkg::*; ();

   localparam int DEPTH = 16;
   localparam longint unsigned MODULUS = 64'd1000000007;

   // Idle odds per phase, in percent: sender first, then receiver.
   localparam int SEND_IDLE [3] = '{34, 47, 0};
   localparam int RECV_IDLE [3] = '{47, 34, 0};

   // Base settings for the random phases: edges of the field first.
   localparam logic [WORD_W-1:0] BASE_CORNERS [7] = '{
      WORD_W'(2), HASH_PRIME - ONE_VALUE, '0, HASH_PRIME, '1, ONE_VALUE, BASE_RESET
   };

   typedef enum logic {ROW_ITEM, ROW_BASE} row_kind_type;

   // One row of the directed plan. On a ROW_BASE row, word is the new base.
   // On a ROW_ITEM row with known set, word and status are the result beat
   // typed in by hand; otherwise the hash predictor supplies it.
   typedef struct packed {
      row_kind_type      kind;
      logic              func;
      logic              restart;
      logic [7:0]        code;
      logic [3:0]        first;
      logic [3:0]        last;
      logic              known;
      logic [WORD_W-1:0] word;
      logic [1:0]        status;
   } plan_row_type;

   localparam int PLAN_LEN = 29;
   localparam plan_row_type DIRECTED_PLAN [PLAN_LEN] = '{
      // query on the empty string right after reset
      '{ROW_ITEM, FUNC_QUERY,  1'b0, 8'd0,   4'd0,  4'd0,  1'b1, 30'd0, STATUS_BAD_QUERY},
      // append at position zero after reset, no restart: 'a' has value 1
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd97,  4'd3,  4'd9,  1'b1, 30'd1, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd0,   4'd15, 4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd255, 4'd0,  4'd15, 1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd96,  4'd5,  4'd5,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd122, 4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd1,   4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd95,  4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd128, 4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd200, 4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd109, 4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd64,  4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd32,  4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd16,  4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd240, 4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd170, 4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd85,  4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      // seventeenth append without restart: string full
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd98,  4'd0,  4'd0,  1'b1, 30'd0, STATUS_FULL},
      '{ROW_ITEM, FUNC_QUERY,  1'b0, 8'd0,   4'd0,  4'd15, 1'b0, 30'd0, STATUS_OK},
      // restart bit on a query is ignored
      '{ROW_ITEM, FUNC_QUERY,  1'b1, 8'd255, 4'd15, 4'd15, 1'b0, 30'd0, STATUS_OK},
      // start after end
      '{ROW_ITEM, FUNC_QUERY,  1'b0, 8'd0,   4'd5,  4'd4,  1'b1, 30'd0, STATUS_BAD_QUERY},
      '{ROW_BASE, FUNC_APPEND, 1'b0, 8'd0,   4'd0,  4'd0,  1'b0, 30'd1000000006, STATUS_OK},
      // restart on a full string
      '{ROW_ITEM, FUNC_APPEND, 1'b1, 8'd97,  4'd0,  4'd0,  1'b1, 30'd1, STATUS_OK},
      // change the base inside a string, to a value above the prime
      '{ROW_BASE, FUNC_APPEND, 1'b0, 8'd0,   4'd0,  4'd0,  1'b0, 30'h3FFFFFFF, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd99,  4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_QUERY,  1'b0, 8'd0,   4'd1,  4'd1,  1'b0, 30'd0, STATUS_OK},
      // base of zero: no inverse, hash degenerates
      '{ROW_BASE, FUNC_APPEND, 1'b0, 8'd0,   4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b1, 8'd98,  4'd0,  4'd0,  1'b1, 30'd2, STATUS_OK},
      '{ROW_ITEM, FUNC_APPEND, 1'b0, 8'd99,  4'd0,  4'd0,  1'b0, 30'd0, STATUS_OK}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sph_req_type       req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sph_rsp_type       rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [WORD_W-1:0] csr_wr_data = '0;

   int unsigned send_idle_pct = SEND_IDLE[0];
   int unsigned recv_idle_pct = RECV_IDLE[0];
   int unsigned mismatch_count = 0;

   // Result beats still owed by the block, oldest first.
   sph_rsp_type expected_hashes [$];

   // Shadow copy of the hash state.
   logic [WORD_W-1:0] base_setting = BASE_RESET;
   longint unsigned   prefix_sums [DEPTH];
   longint unsigned   inv_powers [DEPTH];
   longint unsigned   power_now = 1;
   longint unsigned   base_inv = 0;
   int unsigned       model_length = 0;

   substring_polynomial_hash_unit #(
      .MAX_LENGTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
      return (a * b) % MODULUS;
   endfunction

   function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e);
      longint unsigned acc;
      acc = 1;
      while (e != 0) begin
         if ((e & 1) != 0)
            acc = mul_mod(acc, b);
         b = mul_mod(b, b);
         e = e >> 1;
      end
      return acc;
   endfunction

   // Advance the shadow state by one accepted beat and return the result beat
   // it must produce.
   function automatic sph_rsp_type predict_hash(sph_req_type item);
      longint unsigned b, code, val, prev, lo, diff;
      int unsigned     pos;
      sph_rsp_type     res;
      res = '{hash_value: '0, status: STATUS_OK};
      b = base_setting;
      b = b % MODULUS;
      if (item.func == FUNC_APPEND) begin
         if (item.restart)
            model_length = 0;
         if (model_length >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            pos = model_length;
            code = item.char_code;
            // Characters below the offset wrap to the top of the field.
            val = (code >= CHAR_OFFSET) ? code - CHAR_OFFSET : MODULUS - (CHAR_OFFSET - code);
            if (pos == 0) begin
               // New string: reset the power and take the inverse of this base.
               power_now = 1;
               base_inv = pow_mod(b, MODULUS - 2);
               inv_powers[0] = 1;
               prev = 0;
            end else begin
               inv_powers[pos] = mul_mod(inv_powers[pos - 1], base_inv);
               prev = prefix_sums[pos - 1];
            end
            prefix_sums[pos] = (prev + mul_mod(power_now, val)) % MODULUS;
            power_now = mul_mod(power_now, b);
            model_length = pos + 1;
            res.hash_value = WORD_W'(prefix_sums[pos]);
         end
      end else begin
         if (item.query_start > item.query_end || item.query_end >= model_length) begin
            res.status = STATUS_BAD_QUERY;
         end else begin
            lo = (item.query_start == 0) ? 0 : prefix_sums[item.query_start - 1];
            diff = (prefix_sums[item.query_end] + MODULUS - lo) % MODULUS;
            res.hash_value = WORD_W'(mul_mod(diff, inv_powers[item.query_start]));
         end
      end
      return res;
   endfunction

   // Random beat: mostly strings built up from a restart with valid queries
   // between appends, the rest random queries, maybe out of range or inverted.
   function automatic sph_req_type draw_request();
      sph_req_type item;
      int unsigned pick;
      item = '{func: FUNC_APPEND, restart: 1'b0, char_code: 8'($urandom),
               query_start: 4'($urandom), query_end: 4'($urandom)};
      if ($urandom_range(9) < 7)
         item.char_code = 8'($urandom_range(97, 122));
      pick = $urandom_range(99);
      if (model_length == 0 || pick < 4) begin
         item.restart = 1'b1;
      end else if (pick >= 50) begin
         item.func = FUNC_QUERY;
         item.restart = 1'($urandom);
         if (pick < 90) begin
            item.query_end = 4'($urandom_range(model_length - 1));
            item.query_start = 4'($urandom_range(item.query_end));
         end
      end
      return item;
   endfunction

   function automatic void flag_mismatch(string note);
      if (mismatch_count < 10)
         $display("%0t: %s", $time, note);
      mismatch_count++;
   endfunction

   // Wait until every owed result beat has come back, or give up after limit.
   task automatic settle_hashes(input int unsigned limit);
      int unsigned waited;
      waited = 0;
      while (expected_hashes.size() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Drop valid, drain the block, then write the base while it sits idle.
   task automatic load_base(input logic [WORD_W-1:0] value);
      req_valid <= 1'b0;
      settle_hashes(100000);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_setting = value;
   endtask

   // Present one beat, hold it until accepted, then queue its result.
   // Each cycle before the beat goes out, the sender idles with the current
   // odds. Valid is left high so a following beat goes out back to back.
   task automatic issue_item(input sph_req_type item, input bit known,
                             input sph_rsp_type known_rsp);
      sph_rsp_type want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      want = predict_hash(item);
      if (known)
         want = known_rsp;
      expected_hashes.push_back(want);
   endtask

   // Result side: check each accepted beat against the oldest owed one, and
   // redraw the stall for the next edge.
   always @(posedge clock) begin
      sph_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hashes.size() == 0) begin
            flag_mismatch($sformatf("result beat with none owed: hash %0d status %0d",
                                    rsp_data.hash_value, rsp_data.status));
         end else begin
            want = expected_hashes.pop_front();
            if (rsp_data.hash_value !== want.hash_value || rsp_data.status !== want.status)
               flag_mismatch($sformatf(
                  "result beat: expected hash %0d status %0d, got hash %0d status %0d",
                  want.hash_value, want.status, rsp_data.hash_value, rsp_data.status));
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   initial begin
      sph_req_type  item;
      sph_rsp_type  fixed;
      plan_row_type row;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed plan: corners of every field and the special cases.
      for (int n = 0; n < PLAN_LEN; n++) begin
         row = DIRECTED_PLAN[n];
         if (row.kind == ROW_BASE) begin
            load_base(row.word);
         end else begin
            item = '{func: row.func, restart: row.restart, char_code: row.code,
                     query_start: row.first, query_end: row.last};
            fixed = '{hash_value: row.word, status: row.status};
            issue_item(item, row.known, fixed);
         end
      end

      // Random part: three idle profiles, five base settings in each.
      // Strings carry across base writes, so bases also change mid-string.
      fixed = '0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = SEND_IDLE[phase];
         recv_idle_pct = RECV_IDLE[phase];
         for (int seg = 0; seg < 5; seg++) begin
            if (phase * 5 + seg < 7)
               load_base(BASE_CORNERS[phase * 5 + seg]);
            else if (seg % 2 == 0)
               load_base(WORD_W'($urandom));
            else
               load_base(WORD_W'($urandom_range(2, 1000000006)));
            repeat (100) issue_item(draw_request(), 1'b0, fixed);
         end
      end

      req_valid <= 1'b0;
      settle_hashes(200000);
      repeat (1000) @(posedge clock);
      // Anything still owed never arrived.
      mismatch_count += expected_hashes.size();
      if (mismatch_count == 0)
         $display("PASS substring_polynomial_hash_unit");
      else
         $display("FAIL substring_polynomial_hash_unit");
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #(70_000_000);
      $display("FAIL substring_polynomial_hash_unit");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sph_pkg.sv
rtl/sph_modmul.sv
rtl/substring_polynomial_hash_unit.sv
dv/testbench.sv
